>>> src/fia_pkg.sv
// ----------------------------------------------------------------------------
// Flow ID assigner package
// Shared widths, the flow key layout and the token that walks the cell row.
// ----------------------------------------------------------------------------
package fia_pkg;

   localparam int ADDR_WIDTH            = 32;
   localparam int PORT_WIDTH            = 16;
   localparam int NUMBER_WIDTH          = 9;
   localparam int TABLE_ENTRIES_DEFAULT = 256;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] source_address;
      logic [ADDR_WIDTH-1:0] destination_address;
      logic [PORT_WIDTH-1:0] source_port;
      logic [PORT_WIDTH-1:0] destination_port;
   } key_type;

   typedef struct packed {
      logic                    valid;
      key_type                 key;
      logic                    hit;
      logic                    first;
      logic [NUMBER_WIDTH-1:0] number;
   } token_type;

endpackage

>>> src/fia_req_if.sv
// ----------------------------------------------------------------------------
// Flow ID assigner request channel
// Valid/ready channel that carries one packet four-tuple per word.
// ----------------------------------------------------------------------------
interface fia_req_if;
   logic                            valid;
   logic                            ready;
   logic [fia_pkg::ADDR_WIDTH-1:0]  source_address;
   logic [fia_pkg::PORT_WIDTH-1:0]  source_port;
   logic [fia_pkg::ADDR_WIDTH-1:0]  destination_address;
   logic [fia_pkg::PORT_WIDTH-1:0]  destination_port;

   modport source (
      output valid, source_address, source_port, destination_address, destination_port,
      input  ready
   );

   modport sink (
      input  valid, source_address, source_port, destination_address, destination_port,
      output ready
   );
endinterface

>>> src/fia_rsp_if.sv
// ----------------------------------------------------------------------------
// Flow ID assigner response channel
// Valid/ready channel that carries one flow number result per word.
// ----------------------------------------------------------------------------
interface fia_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fia_pkg::NUMBER_WIDTH-1:0] flow_id;
   logic                             first_seen;
   logic                             table_full;

   modport source (
      output valid, flow_id, first_seen, table_full,
      input  ready
   );

   modport sink (
      input  valid, flow_id, first_seen, table_full,
      output ready
   );
endinterface

>>> src/fia_cell.sv
// ----------------------------------------------------------------------------
// Flow ID assigner cell
// Holds one flow key, compares it with the passing token and stores the
// token's key when this cell is the first free entry and nothing matched.
// ----------------------------------------------------------------------------
module fia_cell #(
   parameter int INDEX       = 0,
   parameter int COUNT_WIDTH = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [COUNT_WIDTH-1:0] count,
   input  fia_pkg::token_type     tok_in,
   output fia_pkg::token_type     tok_out,
   output logic                   insert
);
   import fia_pkg::*;

   localparam logic [COUNT_WIDTH-1:0]  CELL_INDEX  = COUNT_WIDTH'(INDEX);
   localparam logic [NUMBER_WIDTH-1:0] CELL_NUMBER = NUMBER_WIDTH'(INDEX + 1);

   key_type   key_ff;
   token_type tok_ff;
   token_type tok_in_next;
   logic      used;
   logic      match;

   always_comb begin
      used   = count > CELL_INDEX;
      match  = tok_in.valid && used && (key_ff == tok_in.key);
      insert = advance && tok_in.valid && !tok_in.hit && !tok_in.first &&
               (count == CELL_INDEX);
      tok_in_next = tok_in;
      if (match || insert) begin
         tok_in_next.number = CELL_NUMBER;
      end
      tok_in_next.hit   = tok_in.hit | match;
      tok_in_next.first = tok_in.first | insert;
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         key_ff <= tok_in.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> src/flow_id_assigner.sv
// ----------------------------------------------------------------------------
// Flow ID assigner
// Exact-match flow table built as a row of cells. Each request word walks the
// row one cell per cycle; the cell holding its key gives the flow number, and
// a miss is stored in the first free cell, which numbers flows from 1.
//
//   Channel   Direction   Payload
//   req       in          source_address, source_port, destination_address,
//                         destination_port
//   rsp       out         flow_id, first_seen, table_full
//
// One request word is taken per cycle while the response side moves.
// Each word reaches the response port through the cell registers in row order;
// the last cell register is the response register.
// Words stay in order; a word stored by a miss is seen by every later word.
// Reset clears the fill count and the word valid flags; stored keys are not
// cleared and are never compared until written.
// A response word that waits holds the whole row, and req.ready drops with it.
// ----------------------------------------------------------------------------
module flow_id_assigner #(
   parameter int TABLE_ENTRIES = fia_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fia_req_if.sink   req,
   fia_rsp_if.source rsp
);
   import fia_pkg::*;

   localparam int COUNT_WIDTH = $clog2(TABLE_ENTRIES + 1);

   token_type               tok [0:TABLE_ENTRIES];
   token_type               head_tok;
   logic [TABLE_ENTRIES-1:0] insert_vec;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic                    advance;

   assign advance   = !tok[TABLE_ENTRIES].valid || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      head_tok.valid                   = req.valid;
      head_tok.key.source_address      = req.source_address;
      head_tok.key.destination_address = req.destination_address;
      head_tok.key.source_port         = req.source_port;
      head_tok.key.destination_port    = req.destination_port;
      head_tok.hit                     = 1'b0;
      head_tok.first                   = 1'b0;
      head_tok.number                  = '0;
   end

   assign tok[0] = head_tok;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      fia_cell #(
         .INDEX       (k),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .count   (count_ff),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1]),
         .insert  (insert_vec[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (|insert_vec) begin
         count_ff <= count_ff + COUNT_WIDTH'(1);
      end
   end

   assign rsp.valid      = tok[TABLE_ENTRIES].valid;
   assign rsp.flow_id    = tok[TABLE_ENTRIES].number;
   assign rsp.first_seen = tok[TABLE_ENTRIES].first;
   assign rsp.table_full = !tok[TABLE_ENTRIES].hit && !tok[TABLE_ENTRIES].first;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(TABLE_ENTRIES))
      else $error("fill count exceeds the table size");

   a_single_insert : assert property (@(posedge clock) disable iff (reset)
      $onehot0(insert_vec))
      else $error("more than one cell stored a key in one cycle");

   a_no_insert_full : assert property (@(posedge clock) disable iff (reset)
      (count_ff == COUNT_WIDTH'(TABLE_ENTRIES)) |-> (insert_vec == '0))
      else $error("key stored while the table is full");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (|insert_vec) |=> (count_ff == $past(count_ff) + COUNT_WIDTH'(1)))
      else $error("fill count did not follow a stored key");

endmodule
